// ===== rtl/sawbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sawbc_pkg
// shared widths, defaults and register codes of the cache tag block
// ----------------------------------------------------------------------------
`default_nettype none

package sawbc_pkg;

    // default geometry
    localparam int DEF_NUM_SETS    = 8;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_OFFSET_BITS = 5;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int LAT_W       = 10;
    localparam int PENALTY_W   = 11;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_READ_LAT  = 2'd1,
        CFG_WRITE_LAT = 2'd2
    } cfg_index_t;

    // request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // register values after reset
    localparam logic             RST_ENABLE    = 1'b1;
    localparam logic [LAT_W-1:0] RST_READ_LAT  = 10'd30;
    localparam logic [LAT_W-1:0] RST_WRITE_LAT = 10'd10;

endpackage

`default_nettype wire

// ===== rtl/sawbc_if.sv =====
// ----------------------------------------------------------------------------
// sawbc request and response channels
// valid/ready channels for memory accesses and their lookup results
// ----------------------------------------------------------------------------
`default_nettype none

interface sawbc_req_if;
    import sawbc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

interface sawbc_rsp_if;
    import sawbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PENALTY_W-1:0] penalty;
    logic                 hit;
    logic                 writeback;
    logic [COUNT_W-1:0]   load_count;
    logic [COUNT_W-1:0]   store_count;
    logic [COUNT_W-1:0]   load_miss_count;
    logic [COUNT_W-1:0]   store_miss_count;
    logic [COUNT_W-1:0]   writeback_count;

    modport source (
        output valid, output penalty, output hit, output writeback,
        output load_count, output store_count, output load_miss_count,
        output store_miss_count, output writeback_count,
        input  ready
    );
    modport sink (
        input  valid, input penalty, input hit, input writeback,
        input  load_count, input store_count, input load_miss_count,
        input  store_miss_count, input writeback_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/set_assoc_writeback_cache_tags.sv =====
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// Tag and status tracker of a set-associative, write-back, write-allocate data
// cache with round-robin replacement. Each request carries a load or store
// byte address; the block splits it into set index and tag, compares all ways
// of the set at once and returns one response per request: the penalty in
// cycles (0 on a hit, read latency on a miss, plus write latency when the
// victim was dirty), hit and writeback flags, and the five statistic counters
// after this access. It takes one request per cycle while the response channel
// is not stalled: a request is captured in an input register when accepted,
// looked up from that register and written, together with the set state
// update, into the response register once that register is free or being
// emptied. With the cache disabled the response carries the raw latency of
// the access and nothing is counted. Tags, valid and dirty bits and the victim
// pointers live in flip-flops; valid, dirty, pointers and counters clear at
// reset, no clearing pass is needed. NUM_SETS must be a power of two.
// Configuration must be written only while idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_writeback_cache_tags #(
    parameter int NUM_SETS    = sawbc_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS    = sawbc_pkg::DEF_NUM_WAYS,
    parameter int OFFSET_BITS = sawbc_pkg::DEF_OFFSET_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sawbc_req_if.sink                         req,
    sawbc_rsp_if.source                       rsp,
    input  logic                              cfg_we,
    input  logic [sawbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sawbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sawbc_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int TAG_W = ADDR_W - OFFSET_BITS - SET_W;
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

    // configuration registers
    logic             enable_reg;
    logic [LAT_W-1:0] read_lat_reg;
    logic [LAT_W-1:0] write_lat_reg;

    // input register
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [SET_W-1:0] in_set_reg;
    logic [TAG_W-1:0] in_tag_reg;

    // response register
    logic                 out_valid_reg;
    logic [PENALTY_W-1:0] out_penalty_reg;
    logic                 out_hit_reg;
    logic                 out_wb_reg;

    // per-set state
    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] dirty_reg [NUM_SETS];
    logic [TAG_W-1:0]    tag_reg   [NUM_SETS][NUM_WAYS];
    logic [WAY_W-1:0]    ptr_reg   [NUM_SETS];

    // statistic counters, always the values after the request in the
    // response register
    logic [COUNT_W-1:0] loads_reg,  loads_next;
    logic [COUNT_W-1:0] stores_reg, stores_next;
    logic [COUNT_W-1:0] load_miss_reg,  load_miss_next;
    logic [COUNT_W-1:0] store_miss_reg, store_miss_next;
    logic [COUNT_W-1:0] wb_count_reg,   wb_count_next;

    logic                 advance;
    logic                 is_store;
    logic [NUM_WAYS-1:0]  hit_vec;
    logic                 hit_any;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     victim;
    logic                 victim_dirty;
    logic [WAY_W-1:0]     ptr_next;
    logic [PENALTY_W-1:0] penalty_next;
    logic                 wb_next;

    // ------------------------------------------------------------------
    // handshake: the lookup moves into the response register whenever
    // that register is free or being emptied this cycle
    // ------------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign is_store  = (in_kind_reg == KIND_STORE);

    // ------------------------------------------------------------------
    // configuration writes, unknown indexes ignored
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= RST_ENABLE;
            read_lat_reg  <= RST_READ_LAT;
            write_lat_reg <= RST_WRITE_LAT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg    <= cfg_data[0];
                CFG_READ_LAT:  read_lat_reg  <= cfg_data[LAT_W-1:0];
                CFG_WRITE_LAT: write_lat_reg <= cfg_data[LAT_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register: line number split into set index and tag
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg <= req.kind;
            in_set_reg  <= req.address[OFFSET_BITS +: SET_W];
            in_tag_reg  <= req.address[ADDR_W-1 -: TAG_W];
        end
    end

    // ------------------------------------------------------------------
    // lookup: parallel compare of all ways, lowest matching way wins
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            hit_vec[w] = valid_reg[in_set_reg][w] && (tag_reg[in_set_reg][w] == in_tag_reg);
        end
        hit_any = |hit_vec;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
    end

    // victim under the round-robin pointer, pointer wraps at the last way
    assign victim       = ptr_reg[in_set_reg];
    assign victim_dirty = dirty_reg[in_set_reg][victim];
    assign ptr_next     = (victim == LAST_WAY) ? '0 : victim + 1'b1;

    // penalty and writeback flag
    always_comb
    begin
        penalty_next = '0;
        wb_next      = 1'b0;
        if (!enable_reg)
        begin
            // disabled: raw memory latency of the access
            penalty_next = is_store ? PENALTY_W'(write_lat_reg) : PENALTY_W'(read_lat_reg);
        end
        else if (!hit_any)
        begin
            wb_next      = victim_dirty;
            penalty_next = PENALTY_W'(read_lat_reg)
                         + (victim_dirty ? PENALTY_W'(write_lat_reg) : '0);
        end
    end

    // counter next values, only used while enabled
    always_comb
    begin
        loads_next      = loads_reg;
        stores_next     = stores_reg;
        load_miss_next  = load_miss_reg;
        store_miss_next = store_miss_reg;
        wb_count_next   = wb_count_reg;
        if (is_store)
        begin
            stores_next = stores_reg + 1'b1;
            if (!hit_any)
            begin
                store_miss_next = store_miss_reg + 1'b1;
            end
        end
        else
        begin
            loads_next = loads_reg + 1'b1;
            if (!hit_any)
            begin
                load_miss_next = load_miss_reg + 1'b1;
            end
        end
        if (!hit_any && victim_dirty)
        begin
            wb_count_next = wb_count_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // set state and counters, updated as the request leaves the lookup
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
                ptr_reg[s]   <= '0;
            end
            loads_reg      <= '0;
            stores_reg     <= '0;
            load_miss_reg  <= '0;
            store_miss_reg <= '0;
            wb_count_reg   <= '0;
        end
        else if (advance && enable_reg)
        begin
            if (hit_any)
            begin
                // store hit marks the line dirty
                if (is_store)
                begin
                    dirty_reg[in_set_reg][hit_way] <= 1'b1;
                end
            end
            else
            begin
                // allocate on miss, dirty only for a store
                valid_reg[in_set_reg][victim] <= 1'b1;
                dirty_reg[in_set_reg][victim] <= is_store;
                ptr_reg[in_set_reg]           <= ptr_next;
            end
            loads_reg      <= loads_next;
            stores_reg     <= stores_next;
            load_miss_reg  <= load_miss_next;
            store_miss_reg <= store_miss_next;
            wb_count_reg   <= wb_count_next;
        end
    end

    // tag store, no reset: a way is only compared once valid
    always_ff @(posedge clk)
    begin
        if (advance && enable_reg && !hit_any)
        begin
            tag_reg[in_set_reg][victim] <= in_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_penalty_reg <= penalty_next;
            out_hit_reg     <= enable_reg && hit_any;
            out_wb_reg      <= enable_reg && wb_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.penalty          = out_penalty_reg;
    assign rsp.hit              = out_hit_reg;
    assign rsp.writeback        = out_wb_reg;
    assign rsp.load_count       = loads_reg;
    assign rsp.store_count      = stores_reg;
    assign rsp.load_miss_count  = load_miss_reg;
    assign rsp.store_miss_count = store_miss_reg;
    assign rsp.writeback_count  = wb_count_reg;

endmodule

`default_nettype wire

// ===== rtl/sawbc_checker.sv =====
// ----------------------------------------------------------------------------
// sawbc_checker
// port-level checks on the cache tag block's response channel
// ----------------------------------------------------------------------------
`default_nettype none

module sawbc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            rsp_hit,
    input wire logic                            rsp_writeback,
    input wire logic [sawbc_pkg::PENALTY_W-1:0] rsp_penalty
);
    import sawbc_pkg::*;

    // a hit costs nothing
    a_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_penalty == '0)
        else $error("hit response with nonzero penalty");

    // a writeback only happens on a miss
    a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_writeback |-> !rsp_hit)
        else $error("writeback flagged on a hit");

    // stalled response stays
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // stalled response holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_penalty) && $stable(rsp_hit) && $stable(rsp_writeback))
        else $error("response payload changed while stalled");

endmodule

bind set_assoc_writeback_cache_tags sawbc_checker u_sawbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit       (rsp.hit),
    .rsp_writeback (rsp.writeback),
    .rsp_penalty   (rsp.penalty)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression of the cache tag block. Memory accesses are fed through the
// request channel from a queue, and every response is checked field by field
// against an in-bench tag and status predictor. The run covers several latency
// and enable settings, random stalls on both channels and drain pauses.
// ----------------------------------------------------------------------------

module testbench;
    import sawbc_pkg::*;

    // geometry, kept in step with the block defaults
    localparam int NUM_SETS    = DEF_NUM_SETS;
    localparam int NUM_WAYS    = DEF_NUM_WAYS;
    localparam int OFFSET_BITS = DEF_OFFSET_BITS;
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_W;

    // bench timing
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int TAIL_CYCLES     = 4;
    localparam int ITEMS_PER_PHASE = 150;
    // longest quiet stretch allowed: random stalls stay far below this
    localparam int WATCHDOG_LIMIT  = 2000;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(3);

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] address;
        bit                drain_first;   // hold this request until all responses are in
    } mem_access_t;

    typedef struct packed {
        logic [PENALTY_W-1:0] penalty;
        logic                 hit;
        logic                 writeback;
        logic [COUNT_W-1:0]   loads;
        logic [COUNT_W-1:0]   stores;
        logic [COUNT_W-1:0]   ld_miss_cnt;
        logic [COUNT_W-1:0]   st_miss_cnt;
        logic [COUNT_W-1:0]   writebacks;
    } lookup_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sawbc_req_if req ();
    sawbc_rsp_if rsp ();

    set_assoc_writeback_cache_tags #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: tags, status bits, round-robin pointers and counters
    // status bits, pointers and counters start cleared, as after reset
    // ------------------------------------------------------------------------
    logic [TAG_W-1:0] tag_store   [NUM_SETS][NUM_WAYS];
    bit               valid_bits  [NUM_SETS][NUM_WAYS];
    bit               dirty_bits  [NUM_SETS][NUM_WAYS];
    bit [WAY_W-1:0]   next_victim [NUM_SETS];
    bit [COUNT_W-1:0] loads_total;
    bit [COUNT_W-1:0] stores_total;
    bit [COUNT_W-1:0] ld_miss_total;
    bit [COUNT_W-1:0] st_miss_total;
    bit [COUNT_W-1:0] writebacks_total;

    // predictor copy of the registers
    logic             model_enable    = RST_ENABLE;
    logic [LAT_W-1:0] model_read_lat  = RST_READ_LAT;
    logic [LAT_W-1:0] model_write_lat = RST_WRITE_LAT;

    // bench bookkeeping
    mem_access_t    pending_accesses [$];
    lookup_result_t expected_results [$];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             failures    = 0;
    int             idle_cycles = 0;
    logic           req_taken   = 1'b0;
    mem_access_t    next_access;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: one lookup, updating the bench copy of the cache state
    // ------------------------------------------------------------------------
    function automatic lookup_result_t predict_access(input logic kind,
                                                      input logic [ADDR_W-1:0] address);
        lookup_result_t   r;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] victim;
        bit               found;
        r       = '0;
        set_idx = address[OFFSET_BITS +: SET_W];
        tag     = address[ADDR_W-1 -: TAG_W];
        found   = 1'b0;
        if (model_enable)
        begin
            if (kind == KIND_STORE)
                stores_total++;
            else
                loads_total++;
            // all ways compared at once, first valid match wins
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (!found && valid_bits[set_idx][w] && tag_store[set_idx][w] == tag)
                begin
                    found = 1'b1;
                    if (kind == KIND_STORE)
                        dirty_bits[set_idx][w] = 1'b1;
                end
            end
            if (!found)
            begin
                // write-allocate into the way under the round-robin pointer
                victim = next_victim[set_idx];
                if (dirty_bits[set_idx][victim])
                begin
                    r.writeback = 1'b1;
                    writebacks_total++;
                    r.penalty = r.penalty + PENALTY_W'(model_write_lat);
                end
                r.penalty = r.penalty + PENALTY_W'(model_read_lat);
                if (kind == KIND_STORE)
                    st_miss_total++;
                else
                    ld_miss_total++;
                dirty_bits[set_idx][victim] = (kind == KIND_STORE);
                tag_store[set_idx][victim]  = tag;
                valid_bits[set_idx][victim] = 1'b1;
                next_victim[set_idx] = (victim == WAY_W'(NUM_WAYS - 1)) ? '0 : victim + 1'b1;
            end
            r.hit = found;
        end
        else
        begin
            // cache off: raw memory latency, state and counters untouched
            r.penalty = (kind == KIND_STORE) ? PENALTY_W'(model_write_lat)
                                             : PENALTY_W'(model_read_lat);
        end
        r.loads       = loads_total;
        r.stores      = stores_total;
        r.ld_miss_cnt = ld_miss_total;
        r.st_miss_cnt = st_miss_total;
        r.writebacks  = writebacks_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------------
    // request driver and response ready, both change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
            // a new request may go out once the current one has been taken
            if (!req.valid || req_taken)
            begin
                if (pending_accesses.size() != 0
                    && !(pending_accesses[0].drain_first && expected_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    next_access = pending_accesses.pop_front();
                    req.valid   <= 1'b1;
                    req.kind    <= next_access.kind;
                    req.address <= next_access.address;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each accepted request, checks each accepted
    // response against the oldest prediction, and feeds the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req.valid && req.ready;
            if (req.valid && req.ready)
                expected_results.push_back(predict_access(req.kind, req.address));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: response with no request outstanding, expected none, %s %0d",
                             $time, "actual penalty", rsp.penalty);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("penalty", want.penalty, rsp.penalty);
                    check_field("hit", want.hit, rsp.hit);
                    check_field("writeback", want.writeback, rsp.writeback);
                    check_field("load_count", want.loads, rsp.load_count);
                    check_field("store_count", want.stores, rsp.store_count);
                    check_field("load_miss_count", want.ld_miss_cnt, rsp.load_miss_count);
                    check_field("store_miss_count", want.st_miss_cnt, rsp.store_miss_count);
                    check_field("writeback_count", want.writebacks, rsp.writeback_count);
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: too long without any handshake means the block has hung
    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired at %0t ns", $time);
        $display("set_assoc_writeback_cache_tags regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------------
    task automatic queue_access(input logic kind, input logic [ADDR_W-1:0] address,
                                input bit drain_first);
        mem_access_t a;
        a.kind        = kind;
        a.address     = address;
        a.drain_first = drain_first;
        pending_accesses.push_back(a);
    endtask

    // sampled just after the falling edge, once the driver has settled
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_accesses.size() != 0 || req.valid || expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            CFG_ENABLE:    model_enable    = data[0];
            CFG_READ_LAT:  model_read_lat  = data[LAT_W-1:0];
            CFG_WRITE_LAT: model_write_lat = data[LAT_W-1:0];
            default:       ;
        endcase
    endtask

    // only called with the block idle, so the predictor can switch at once
    task automatic configure(input logic [CFG_DATA_W-1:0] enable_data,
                             input logic [CFG_DATA_W-1:0] read_lat,
                             input logic [CFG_DATA_W-1:0] write_lat);
        write_register(CFG_ENABLE, enable_data);
        write_register(CFG_READ_LAT, read_lat);
        write_register(CFG_WRITE_LAT, write_lat);
        write_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        #1;
    endtask

    // mostly a small pool of tags so sets fill, hit and evict dirty lines,
    // with some fully random addresses mixed in
    task automatic queue_random_accesses(input int count);
        logic [TAG_W-1:0]  tag_pool [8];
        logic [ADDR_W-1:0] address;
        int                pool_size;
        int                hold_at;
        pool_size   = $urandom_range(8, 3);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int t = 2; t < 8; t++)
            tag_pool[t] = TAG_W'($urandom);
        hold_at = $urandom_range(count - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 15)
                address = $urandom;
            else
                address = {tag_pool[$urandom_range(pool_size - 1)],
                           SET_W'($urandom_range(NUM_SETS - 1)),
                           OFFSET_BITS'($urandom)};
            queue_access($urandom_range(1) ? KIND_STORE : KIND_LOAD, address, i == hold_at);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] enable_data,
                             input logic [CFG_DATA_W-1:0] read_lat,
                             input logic [CFG_DATA_W-1:0] write_lat,
                             input int send_pct, input int recv_pct);
        wait_drained();
        configure(enable_data, read_lat, write_lat);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random_accesses(ITEMS_PER_PHASE);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        req.valid     = 1'b0;
        req.kind      = KIND_LOAD;
        req.address   = '0;
        rsp.ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ENABLE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 71;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        #1;

        // directed requests at the reset settings: set 0 is filled past its
        // four ways so that dirty victims get written back
        queue_access(KIND_LOAD,  32'h0000_0000, 1'b0);   // cold miss, set 0 way 0
        queue_access(KIND_LOAD,  32'h0000_001F, 1'b0);   // hit, same line, top offset
        queue_access(KIND_STORE, 32'h0000_0004, 1'b0);   // store hit marks it dirty
        queue_access(KIND_STORE, 32'hFFFF_FFFF, 1'b0);   // store miss, top address
        queue_access(KIND_LOAD,  32'hFFFF_FFE0, 1'b0);   // hit on that line
        queue_access(KIND_LOAD,  32'h0000_0100, 1'b0);   // set 0 way 1
        queue_access(KIND_STORE, 32'h0000_0200, 1'b0);   // set 0 way 2, dirty
        queue_access(KIND_LOAD,  32'h0000_0300, 1'b0);   // set 0 way 3
        queue_access(KIND_LOAD,  32'h0000_0400, 1'b0);   // load evicts a dirty victim
        queue_access(KIND_LOAD,  32'h0000_0000, 1'b0);   // clean victim
        queue_access(KIND_STORE, 32'h0000_0500, 1'b0);   // store evicts a dirty victim
        queue_access(KIND_LOAD,  32'h0000_0300, 1'b1);   // hit, sent after a full drain
        queue_access(KIND_STORE, 32'hFFFF_FFFF, 1'b0);   // store hit on a dirty line
        queue_access(KIND_LOAD,  32'hAAAA_AAAA, 1'b0);
        queue_access(KIND_STORE, 32'h5555_5555, 1'b0);

        // sender idles less than the receiver
        run_phase('1, 10'h3FF, 10'h3FF, 37, 71);                  // largest penalty
        run_phase(10'h3FE, 10'd5, 10'd700, 37, 71);               // off, upper bits ignored
        // receiver idles less than the sender
        run_phase(10'h001, '0, '0, 71, 37);                       // zero latencies
        run_phase(10'h001, CFG_DATA_W'($urandom_range(1023)),
                  CFG_DATA_W'($urandom_range(1023)), 71, 37);
        // no idling at all
        run_phase('0, 10'h3FF, '0, 0, 0);                         // off again
        run_phase(CFG_DATA_W'(RST_ENABLE), CFG_DATA_W'(RST_READ_LAT),
                  CFG_DATA_W'(RST_WRITE_LAT), 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("set_assoc_writeback_cache_tags regression: pass");
        else
            $display("set_assoc_writeback_cache_tags regression: fail");
        $finish;
    end

endmodule
